FILE: rtl/ped_pkg.sv
// Shared types, constants and helpers for the percent-escape decoder.
package ped_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int IDX_W = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] PERCENT_CHAR = 8'h25;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [IDX_W-1:0]            last_idx;
      logic                        done;
   } entry_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= "0" && c <= "9") begin
         h.value = 4'(c - 8'h30);
      end else if (c >= "a" && c <= "f") begin
         h.value = 4'(c - 8'h57);
      end else if (c >= "A" && c <= "F") begin
         h.value = 4'(c - 8'h37);
      end else if (c == "x" || c == "X") begin
         h.value = 4'd0;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: rtl/percent_escape_decoder_top.sv
// Percent-escape decoder: accepts one encoded character per cycle on the req
// channel and delivers decoded characters one per cycle on the rsp channel.
// The front end accepts a transaction every cycle while its entry queue
// (QUEUE_DEPTH entries) has room; each transaction yields zero to three result
// bytes, and the back end drains them at one byte per cycle, so sustained input
// rate is one item per cycle except where an item expands to two or three
// bytes (failed triples and end-of-string flushes). With the output register
// free, the first result passes the entry queue, then the output register.
// rsp_data.run_last marks the last byte of each input transaction and
// rsp_data.string_done the last byte of the string.
module percent_escape_decoder_top
   import ped_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      accept, push, pop, empty, full;
   entry_type entry, head;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ped_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .entry    (entry)
   );

   ped_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ped_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ped_front.sv
// Front end: tracks held characters and builds one queue entry per transaction that yields bytes.
module ped_front
   import ped_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output logic      push,
   output entry_type entry
);

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_PCT   = 2'd1,
      HOLD_DIGIT = 2'd2
   } hold_type;

   hold_type   hold_ff, hold_in;
   logic [7:0] digit_ff, digit_in;

   logic [1:0]                  n;
   logic [MAX_RESULTS-1:0][7:0] b;
   hex_type                     hi, lo;
   logic [7:0]                  c;

   assign c  = req_data.in_byte;
   assign hi = hex_decode(digit_ff);
   assign lo = hex_decode(c);

   always_comb begin
      n        = 2'd0;
      b        = '0;
      hold_in  = hold_ff;
      digit_in = digit_ff;
      case (hold_ff)
         HOLD_NONE: begin
            if (c == PERCENT_CHAR) begin
               hold_in = HOLD_PCT;
            end else begin
               b[0] = c;
               n    = 2'd1;
            end
         end
         HOLD_PCT: begin
            digit_in = c;
            hold_in  = HOLD_DIGIT;
         end
         default: begin
            if (hi.valid && lo.valid && {hi.value, lo.value} != 8'd0) begin
               b[0]     = {hi.value, lo.value};
               n        = 2'd1;
               hold_in  = HOLD_NONE;
               digit_in = 8'd0;
            end else begin
               b[0] = PERCENT_CHAR;
               n    = 2'd1;
               if (digit_ff == PERCENT_CHAR) begin
                  digit_in = c;
                  hold_in  = HOLD_DIGIT;
               end else begin
                  b[1]     = digit_ff;
                  n        = 2'd2;
                  digit_in = 8'd0;
                  if (c == PERCENT_CHAR) begin
                     hold_in = HOLD_PCT;
                  end else begin
                     b[2]    = c;
                     n       = 2'd3;
                     hold_in = HOLD_NONE;
                  end
               end
            end
         end
      endcase
      if (req_data.string_end) begin
         if (hold_in != HOLD_NONE && n != 2'd3) begin
            b[n] = PERCENT_CHAR;
            n    = n + 2'd1;
         end
         if (hold_in != HOLD_NONE && hold_in != HOLD_PCT && n != 2'd3) begin
            b[n] = digit_in;
            n    = n + 2'd1;
         end
         hold_in  = HOLD_NONE;
         digit_in = 8'd0;
      end
   end

   assign push           = accept && (n != 2'd0);
   assign entry.bytes    = b;
   assign entry.last_idx = IDX_W'(n - 2'd1);
   assign entry.done     = req_data.string_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= HOLD_NONE;
         digit_ff <= 8'd0;
      end else if (accept) begin
         hold_ff  <= hold_in;
         digit_ff <= digit_in;
      end
   end

endmodule

FILE: rtl/ped_queue.sv
// Entry queue between the front and back ends.
module ped_queue
   import ped_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type     store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

FILE: rtl/ped_back.sv
// Back end: walks the bytes of each queue entry into the output register.
module ped_back
   import ped_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0] idx_ff;
   logic             load, take, last;

   assign load = !rsp_valid_ff || rsp_ready;
   assign take = load && !empty;
   assign last = (idx_ff == head.last_idx);
   assign pop  = take && last;

   assign rsp_data_in.out_byte    = head.bytes[idx_ff];
   assign rsp_data_in.run_last    = last;
   assign rsp_data_in.string_done = last && head.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !empty;
         end
         if (take) begin
            idx_ff <= last ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/tb_percent_escape_decoder_top.sv
// Testbench for the percent-escape decoder: random strings, backpressure and a scoreboard.
`timescale 1ns / 100ps

module tb_percent_escape_decoder_top
   import ped_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 370;
   localparam int CHOKE_CYCLES = 80;

   class decode_scoreboard;
      rsp_type    decoded_q[$];
      logic [1:0] held_count;
      logic [7:0] held_digit;
      int         mismatches;

      function new();
         held_count = 2'd0;
         held_digit = 8'd0;
         mismatches = 0;
      endfunction

      function int hex_digit(input logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
         if (c == 8'h78 || c == 8'h58) return 0;
         return -1;
      endfunction

      function void note_char(input req_type r);
         logic [7:0] bytes_out[$];
         rsp_type    res;
         logic [7:0] c;
         int         hi;
         int         lo;
         c = r.in_byte;
         case (held_count)
            2'd0: begin
               if (c == PERCENT_CHAR) held_count = 2'd1;
               else bytes_out.push_back(c);
            end
            2'd1: begin
               held_digit = c;
               held_count = 2'd2;
            end
            default: begin
               hi = hex_digit(held_digit);
               lo = hex_digit(c);
               if (hi >= 0 && lo >= 0 && (hi * 16 + lo) != 0) begin
                  bytes_out.push_back(8'(hi * 16 + lo));
                  held_count = 2'd0;
                  held_digit = 8'd0;
               end else begin
                  bytes_out.push_back(PERCENT_CHAR);
                  if (held_digit == PERCENT_CHAR) begin
                     held_digit = c;
                     held_count = 2'd2;
                  end else begin
                     bytes_out.push_back(held_digit);
                     held_digit = 8'd0;
                     if (c == PERCENT_CHAR) begin
                        held_count = 2'd1;
                     end else begin
                        bytes_out.push_back(c);
                        held_count = 2'd0;
                     end
                  end
               end
            end
         endcase
         if (r.string_end) begin
            if (held_count >= 2'd1) bytes_out.push_back(PERCENT_CHAR);
            if (held_count >= 2'd2) bytes_out.push_back(held_digit);
            held_count = 2'd0;
            held_digit = 8'd0;
         end
         foreach (bytes_out[i]) begin
            res.out_byte    = bytes_out[i];
            res.run_last    = (i == bytes_out.size() - 1);
            res.string_done = (i == bytes_out.size() - 1) && r.string_end;
            decoded_q.push_back(res);
         end
      endfunction

      function void check_byte(input rsp_type got);
         rsp_type want;
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: byte %h run_last %b string_done %b",
                        got.out_byte, got.run_last, got.string_done);
            return;
         end
         want = decoded_q.pop_front();
         if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
             got.string_done !== want.string_done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: byte %h/%h run_last %b/%b string_done %b/%b (exp/act)",
                        want.out_byte, got.out_byte, want.run_last, got.run_last,
                        want.string_done, got.string_done);
         end
      endfunction

      function int outstanding();
         return decoded_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   decode_scoreboard sb = new();
   int cycle_count = 0;
   int items_sent  = 0;
   int choke_left  = 0;
   bit calm        = 1'b0;

   percent_escape_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_data);
         if (choke_left > 0) begin
            choke_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < 26) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic last);
      req_type item;
      item.in_byte    = ch;
      item.string_end = last;
      if (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_char(item);
      items_sent++;
   endtask

   task automatic send_chars(input logic [7:0] chars[$]);
      foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
   endtask

   task automatic send_text(input string s);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      send_chars(chars);
   endtask

   function automatic logic [7:0] pick_hex();
      string digits;
      digits = "0123456789abcdefABCDEFxX";
      return digits[$urandom_range(digits.len() - 1)];
   endfunction

   task automatic send_random_string();
      logic [7:0] chars[$];
      int         tokens;
      int         pick;
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            chars.push_back(PERCENT_CHAR);
            chars.push_back(pick_hex());
            chars.push_back(pick_hex());
         end else if (pick < 55) begin
            chars.push_back(PERCENT_CHAR);
            if ($urandom_range(1)) chars.push_back(pick_hex());
         end else if (pick < 70) begin
            chars.push_back(pick_hex());
         end else begin
            chars.push_back(8'($urandom_range(255)));
         end
      end
      send_chars(chars);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("%41");
      send_text("%00");
      send_text("%x1%Fa");
      send_text("%%41");
      send_text("%4%1");
      send_text("%4");
      send_text("%");
      send_item(8'h00, 1'b1);
      send_item(8'hff, 1'b1);

      // hold the sender until every result is back
      req_valid <= 1'b0;
      wait_drained();

      // choke the receiver while the sender keeps offering
      calm       = 1'b1;
      choke_left = CHOKE_CYCLES;
      while (items_sent < 60) send_random_string();
      calm = 1'b0;

      while (items_sent < 60 + RANDOM_ITEMS) begin
         calm = (items_sent > 200 && items_sent < 300);
         send_random_string();
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
